[hdl/sdfreq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfreq_pkg
// Types and constants shared by the synthesizer divider calculation blocks.
// ----------------------------------------------------------------------------
package sdfreq_pkg;

  localparam int FRAC_BITS = 24;
  localparam int FREQ_W    = 56;                    // clamped frequency width
  localparam int DIV_SHIFT = 11;                    // 480e6 = 234375 * 2^11
  localparam int Y_W       = FREQ_W - DIV_SHIFT;    // scaled numerator width
  localparam int EST_IN_W  = 32;                    // numerator bits into estimate
  localparam int EST_DROP  = Y_W - EST_IN_W;
  localparam int RECIP_W   = 28;
  localparam int PROD_W    = EST_IN_W + RECIP_W;
  localparam int QE_W      = 27;                    // quotient estimate width
  localparam int DV_W      = 28;                    // full divider word width
  localparam int REM_W     = 20;                    // remainder width, holds 3 * DIV_D
  localparam int DIVD_W    = 18;

  // Tuning range and band breakpoints, 40.24 fixed point hertz.
  localparam logic [63:0] FREQ_MIN     = 64'd2000000000 << FRAC_BITS;
  localparam logic [63:0] FREQ_MAX     = 64'd3000000000 << FRAC_BITS;
  localparam logic [63:0] BAND_BREAK_A = 64'd2400000000 << FRAC_BITS;
  localparam logic [63:0] BAND_BREAK_B = 64'd2500000000 << FRAC_BITS;
  localparam logic [63:0] BAND_BREAK_C = 64'd2600000000 << FRAC_BITS;

  // Divider = floor((f + 240e6) / 480e6); 480e6 is the divisor constant.
  localparam logic [FREQ_W-1:0] ROUND_OFS = FREQ_W'(240000000);
  localparam logic [DIVD_W-1:0] DIV_D     = DIVD_W'(234375);
  // floor(2^45 / DIV_D), used on the upper 32 numerator bits.
  localparam logic [RECIP_W-1:0] RECIP_M  = RECIP_W'(150119987);

  localparam logic [1:0] BAND_BELOW_A = 2'd0;
  localparam logic [1:0] BAND_BELOW_B = 2'd1;
  localparam logic [1:0] BAND_BELOW_C = 2'd2;
  localparam logic [1:0] BAND_TOP     = 2'd3;

  typedef struct packed {
    logic [63:0] requested_frequency;
    logic        apply_request;
  } sdfreq_in_t;

  typedef struct packed {
    logic [1:0]        band_index;
    logic [7:0]        divider_integer;
    logic [9:0]        fraction_high;
    logic [9:0]        fraction_low;
    logic              apply_strobe;
    logic [FREQ_W-1:0] achieved_frequency;
  } sdfreq_out_t;

  typedef struct packed {
    logic [Y_W-1:0] y;
    logic [1:0]     band;
    logic           apply;
  } sdfreq_b_t;

  typedef struct packed {
    logic [QE_W-1:0] qe;
    logic [Y_W-1:0]  y;
    logic [1:0]      band;
    logic            apply;
  } sdfreq_c_t;

  typedef struct packed {
    logic [QE_W-1:0]  qe;
    logic [Y_W-1:0]   qd;
    logic [REM_W-1:0] y_lo;
    logic [1:0]       band;
    logic             apply;
  } sdfreq_d_t;

  typedef struct packed {
    logic c;
    logic d;
  } sdfreq_quot_en_t;

endpackage

[hdl/synth_divider_from_frequency_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synth_divider_from_frequency_unit
// Fractional-N divider word, band and achieved frequency from a tuning request.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                           Item contents
//   -------  ------------------------------  --------------------------------
//   input    in_valid, in_ready, in_data     requested frequency, apply flag
//   result   out_valid, out_ready, out_data  band, divider, strobe, achieved
//
// Every item passes five registers: the input register, the clamp and band
// stage, the reciprocal estimate multiplier, the back product multiplier and
// the result register. One item is accepted per cycle while the result
// channel is not stalled. Reset clears only the stage valid bits. Each stage
// loads when it is empty or its successor moves, so a stalled result holds
// only the stages behind it and bubbles are still filled.
//
// The divider is floor((f + 240 MHz) / 480 MHz) for the clamped request f.
// The divisor is 234375 * 2^11, so the numerator is shifted right by 11, a
// reciprocal multiply on its upper 32 bits gives a quotient that is low by at
// most two, and the remainder against the back product corrects it. The
// achieved frequency reuses the back product shifted left by 11.
// ----------------------------------------------------------------------------
module synth_divider_from_frequency_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sdfreq_pkg::sdfreq_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sdfreq_pkg::sdfreq_out_t out_data
);
  import sdfreq_pkg::*;

  // Stage valid bits: input register, range stage, estimate, back product, result.
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_o_r;
  logic v_a_nxt, v_b_nxt, v_c_nxt, v_d_nxt, v_o_nxt;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  sdfreq_in_t      in_r;
  sdfreq_b_t       b_item;
  sdfreq_d_t       d_item;
  sdfreq_quot_en_t quot_en;

  // A stage may take a new item when it is empty or its item moves on.
  always_comb begin
    rdy_o = !v_o_r || out_ready;
    rdy_d = !v_d_r || rdy_o;
    rdy_c = !v_c_r || rdy_d;
    rdy_b = !v_b_r || rdy_c;
    rdy_a = !v_a_r || rdy_b;

    v_a_nxt = rdy_a ? in_valid : v_a_r;
    v_b_nxt = rdy_b ? v_a_r    : v_b_r;
    v_c_nxt = rdy_c ? v_b_r    : v_c_r;
    v_d_nxt = rdy_d ? v_c_r    : v_d_r;
    v_o_nxt = rdy_o ? v_d_r    : v_o_r;

    quot_en.c = rdy_c && v_b_r;
    quot_en.d = rdy_d && v_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_b_nxt;
      v_c_r <= v_c_nxt;
      v_d_r <= v_d_nxt;
      v_o_r <= v_o_nxt;
    end
  end

  // Input register; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      in_r <= in_data;
    end
  end

  sdfreq_range u_range (
    .clk     (clk),
    .en      (rdy_b && v_a_r),
    .in_item (in_r),
    .b_item  (b_item)
  );

  sdfreq_quot u_quot (
    .clk    (clk),
    .en     (quot_en),
    .b_item (b_item),
    .d_item (d_item)
  );

  sdfreq_fix u_fix (
    .clk      (clk),
    .en       (rdy_o && v_d_r),
    .d_item   (d_item),
    .out_item (out_data)
  );

  assign in_ready  = rdy_a;
  assign out_valid = v_o_r;

endmodule

[hdl/sdfreq_range.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfreq_range
// Clamps the request, picks the band and forms the scaled numerator.
// ----------------------------------------------------------------------------
module sdfreq_range (
  input  logic                   clk,
  input  logic                   en,
  input  sdfreq_pkg::sdfreq_in_t in_item,
  output sdfreq_pkg::sdfreq_b_t  b_item
);
  import sdfreq_pkg::*;

  logic [63:0]       f_clamp;
  logic [FREQ_W-1:0] f_sum;
  sdfreq_b_t         b_nxt;
  sdfreq_b_t         b_r;

  always_comb begin
    if (in_item.requested_frequency > FREQ_MAX) begin
      f_clamp = FREQ_MAX;
    end else if (in_item.requested_frequency < FREQ_MIN) begin
      f_clamp = FREQ_MIN;
    end else begin
      f_clamp = in_item.requested_frequency;
    end

    if (f_clamp < BAND_BREAK_A) begin
      b_nxt.band = BAND_BELOW_A;
    end else if (f_clamp < BAND_BREAK_B) begin
      b_nxt.band = BAND_BELOW_B;
    end else if (f_clamp < BAND_BREAK_C) begin
      b_nxt.band = BAND_BELOW_C;
    end else begin
      b_nxt.band = BAND_TOP;
    end

    // The clamped value plus the rounding offset stays below 2^56.
    f_sum       = f_clamp[FREQ_W-1:0] + ROUND_OFS;
    b_nxt.y     = f_sum[FREQ_W-1:DIV_SHIFT];
    b_nxt.apply = in_item.apply_request;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r <= b_nxt;
    end
  end

  assign b_item = b_r;

endmodule

[hdl/sdfreq_quot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfreq_quot
// Reciprocal quotient estimate and its back product, one multiplier a stage.
// ----------------------------------------------------------------------------
module sdfreq_quot (
  input  logic                        clk,
  input  sdfreq_pkg::sdfreq_quot_en_t en,
  input  sdfreq_pkg::sdfreq_b_t       b_item,
  output sdfreq_pkg::sdfreq_d_t       d_item
);
  import sdfreq_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [Y_W-1:0]    back;
  sdfreq_c_t         c_nxt;
  sdfreq_c_t         c_r;
  sdfreq_d_t         d_nxt;
  sdfreq_d_t         d_r;

  // The estimate undershoots the true quotient by at most two.
  always_comb begin
    prod        = PROD_W'(b_item.y[Y_W-1:EST_DROP]) * PROD_W'(RECIP_M);
    c_nxt.qe    = prod[EST_IN_W +: QE_W];
    c_nxt.y     = b_item.y;
    c_nxt.band  = b_item.band;
    c_nxt.apply = b_item.apply;
  end

  always_comb begin
    back        = Y_W'(c_r.qe) * Y_W'(DIV_D);
    d_nxt.qe    = c_r.qe;
    d_nxt.qd    = back;
    d_nxt.y_lo  = c_r.y[REM_W-1:0];
    d_nxt.band  = c_r.band;
    d_nxt.apply = c_r.apply;
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      c_r <= c_nxt;
    end
    if (en.d) begin
      d_r <= d_nxt;
    end
  end

  assign d_item = d_r;

endmodule

[hdl/sdfreq_fix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfreq_fix
// Corrects the quotient estimate and packs the result item.
// ----------------------------------------------------------------------------
module sdfreq_fix (
  input  logic                    clk,
  input  logic                    en,
  input  sdfreq_pkg::sdfreq_d_t   d_item,
  output sdfreq_pkg::sdfreq_out_t out_item
);
  import sdfreq_pkg::*;

  logic [REM_W-1:0] rem;
  logic [DV_W-1:0]  dv;
  logic [Y_W-1:0]   add_d;
  logic [Y_W-1:0]   dv_d;
  sdfreq_out_t      out_nxt;
  sdfreq_out_t      out_r;

  always_comb begin
    // The remainder is below three divisors, so its low bits are exact.
    rem = d_item.y_lo - d_item.qd[REM_W-1:0];
    if (rem >= (REM_W'(DIV_D) << 1)) begin
      dv    = DV_W'(d_item.qe) + DV_W'(2);
      add_d = Y_W'(DIV_D) << 1;
    end else if (rem >= REM_W'(DIV_D)) begin
      dv    = DV_W'(d_item.qe) + DV_W'(1);
      add_d = Y_W'(DIV_D);
    end else begin
      dv    = DV_W'(d_item.qe);
      add_d = '0;
    end

    // Achieved frequency is dv * 480e6 = (dv * DIV_D) << 11.
    dv_d                       = d_item.qd + add_d;
    out_nxt.band_index         = d_item.band;
    out_nxt.divider_integer    = dv[DV_W-1:20];
    out_nxt.fraction_high      = dv[19:10];
    out_nxt.fraction_low       = dv[9:0];
    out_nxt.apply_strobe       = d_item.apply;
    out_nxt.achieved_frequency = {dv_d, {DIV_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the synthesizer divider calculation unit.
// ----------------------------------------------------------------------------
// Tuning requests are pushed through the valid/ready input channel in random
// bursts. The expected band, divider word, strobe and achieved frequency are
// computed in plain 64-bit arithmetic. Each result is checked field by field
// against the oldest pending expectation. The sender works in random bursts
// and the receiver stalls on a rotating pattern. Once, the receiver holds off
// for a long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import sdfreq_pkg::*;

  // Constants of the tuning arithmetic in 40.24 fixed point hertz, and the random item count.
  localparam logic [63:0] REF_HZ     = 64'd40000000;
  localparam logic [63:0] ROUND_HALF = (REF_HZ << FRAC_BITS) >> 21;
  localparam logic [63:0] STEP_HZ    = 64'd480000000;  // one divider LSB
  localparam logic [63:0] STEP_HALF  = 64'd240000000;
  localparam int          RANDOM_ITEMS = 750;

  // --------------------------------------------------------------------------
  // Tuning scoreboard: turns each accepted request into the expected result
  // and matches the results against them in order.
  // --------------------------------------------------------------------------
  class tuning_scoreboard;
    sdfreq_out_t tunings_due[$];
    int          errors;

    function sdfreq_out_t compute_tuning(sdfreq_in_t req);
      logic [63:0] f;
      logic [63:0] vco;
      logic [63:0] div_word;
      logic [63:0] achieved;
      sdfreq_out_t res;
      f = req.requested_frequency;
      if (f > FREQ_MAX) f = FREQ_MAX;
      if (f < FREQ_MIN) f = FREQ_MIN;
      if (f < BAND_BREAK_A) res.band_index = BAND_BELOW_A;
      else if (f < BAND_BREAK_B) res.band_index = BAND_BELOW_B;
      else if (f < BAND_BREAK_C) res.band_index = BAND_BELOW_C;
      else res.band_index = BAND_TOP;
      // The VCO runs at 4/3 of the LO; half a divider LSB rounds to nearest.
      vco      = (f * 64'd4) / 64'd3 + ROUND_HALF;
      div_word = (vco / REF_HZ) >> 4;
      achieved = ((REF_HZ * 64'd3) / 64'd4) * (div_word << 4);
      res.divider_integer    = div_word[27:20];
      res.fraction_high      = div_word[19:10];
      res.fraction_low       = div_word[9:0];
      res.apply_strobe       = req.apply_request;
      res.achieved_frequency = achieved[FREQ_W-1:0];
      return res;
    endfunction

    function void note_request(sdfreq_in_t req);
      tunings_due.push_back(compute_tuning(req));
    endfunction

    function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    endfunction

    function void compare_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) report(what, exp_v, act_v);
    endfunction

    function void check_result(sdfreq_out_t got);
      sdfreq_out_t want;
      if (tunings_due.size() == 0) begin
        report("unexpected result item", 64'd0, 64'(got));
        return;
      end
      want = tunings_due.pop_front();
      compare_field("band_index", 64'(want.band_index), 64'(got.band_index));
      compare_field("divider_integer", 64'(want.divider_integer), 64'(got.divider_integer));
      compare_field("fraction_high", 64'(want.fraction_high), 64'(got.fraction_high));
      compare_field("fraction_low", 64'(want.fraction_low), 64'(got.fraction_low));
      compare_field("apply_strobe", 64'(want.apply_strobe), 64'(got.apply_strobe));
      compare_field("achieved_frequency", 64'(want.achieved_frequency),
                    64'(got.achieved_frequency));
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  sdfreq_in_t  in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sdfreq_out_t out_data;

  tuning_scoreboard sb;
  int burst_left;
  int results_seen;

  synth_divider_from_frequency_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; a correct run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("[synth_divider_from_frequency_unit] ERROR");
    $finish;
  end

  // The sender offers items back to back within a burst and idles between
  // bursts. A zero-length burst still gives one item before the next gap.
  function int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 24);
    return $urandom_range(1, 10);
  endfunction

  // Offers one item and holds it until accepted. If a gap follows, valid
  // drops in the same step as the acceptance; otherwise it stays high for
  // the next item so it is never lowered and raised within one step.
  task automatic send_request(sdfreq_in_t req);
    int gap;
    gap = next_gap();
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Directed items: range edges, band breakpoints, a divider rounding edge
  // and the extreme input words. The apply flag alternates.
  task automatic run_directed();
    logic [63:0] freqs [17];
    logic [63:0] step_k;
    logic [63:0] edge_f;
    sdfreq_in_t  req;
    freqs = '{64'd0, '1, FREQ_MIN - 64'd1, FREQ_MIN, FREQ_MIN + 64'd1,
              BAND_BREAK_A - 64'd1, BAND_BREAK_A, BAND_BREAK_B - 64'd1, BAND_BREAK_B,
              BAND_BREAK_C - 64'd1, BAND_BREAK_C, FREQ_MAX - 64'd1, FREQ_MAX,
              FREQ_MAX + 64'd1, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
              64'haaaa_aaaa_aaaa_aaaa};
    for (int i = 0; i < 17; i++) begin
      req.requested_frequency = freqs[i];
      req.apply_request       = i[0];
      send_request(req);
    end
    // The first request at which the divider steps up, and the one just below.
    step_k = (BAND_BREAK_B + STEP_HALF) / STEP_HZ;
    edge_f = STEP_HZ * step_k - STEP_HALF;
    req.requested_frequency = edge_f - 64'd1;
    req.apply_request       = 1'b1;
    send_request(req);
    req.requested_frequency = edge_f;
    req.apply_request       = 1'b0;
    send_request(req);
  endtask

  // Mostly in-range requests with random content, plus requests close to the
  // breakpoints, close to divider rounding edges, and out-of-range noise.
  function sdfreq_in_t random_request();
    sdfreq_in_t  req;
    logic [63:0] r64;
    logic [63:0] base;
    int          sel;
    sel = $urandom_range(0, 99);
    r64 = {$urandom, $urandom};
    if (sel < 55) begin
      req.requested_frequency = FREQ_MIN + r64 % (FREQ_MAX - FREQ_MIN + 64'd1);
    end else if (sel < 70) begin
      case ($urandom_range(0, 4))
        0: base = FREQ_MIN;
        1: base = BAND_BREAK_A;
        2: base = BAND_BREAK_B;
        3: base = BAND_BREAK_C;
        default: base = FREQ_MAX;
      endcase
      req.requested_frequency = base - 64'd32 + 64'($urandom_range(0, 64));
    end else if (sel < 82) begin
      base = FREQ_MIN + r64 % (FREQ_MAX - FREQ_MIN);
      base = STEP_HZ * ((base + STEP_HALF) / STEP_HZ) - STEP_HALF;
      req.requested_frequency = base - 64'd2 + 64'($urandom_range(0, 4));
    end else if (sel < 91) begin
      req.requested_frequency = r64;
    end else begin
      // Mostly below the tuning range.
      req.requested_frequency = r64 >> $urandom_range(8, 63);
    end
    req.apply_request = 1'($urandom_range(0, 1));
    return req;
  endfunction

  // Receiver: rotates through always ready, coin flip, mostly stalled and
  // toggling every cycle. After a few hundred results it holds off once for
  // a long stretch while the sender keeps offering items.
  initial begin
    int   cycle_cnt;
    int   hold_left;
    bit   hold_done;
    logic rdy;
    cycle_cnt = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      if (!hold_done && results_seen >= 250) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (!rst_n) begin
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case ((cycle_cnt >> 6) % 4)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = cycle_cnt[0];
        endcase
      end
      out_ready <= rdy;
      cycle_cnt++;
    end
  end

  // Main sequence: reset, directed items, random items, then drain.
  initial begin
    sb = new();
    burst_left = 0;
    results_seen = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_request(random_request());
    end
    in_valid <= 1'b0;
    while (sb.tunings_due.size() != 0) @(posedge clk);
    // Five stage pipeline; give stray results time to show up.
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.tunings_due.size() == 0) begin
      $display("[synth_divider_from_frequency_unit] OK");
    end else begin
      $display("[synth_divider_from_frequency_unit] ERROR");
    end
    $finish;
  end

endmodule
